// File: hw/rtl/structural_contrast_filter_assert.svh
// Assertion macros for the structural contrast filter.
// Needs a clk_i and an active-low rst_ni in the including module.
`ifndef STRUCTURAL_CONTRAST_FILTER_ASSERT_SVH
`define STRUCTURAL_CONTRAST_FILTER_ASSERT_SVH

// Clocked check, off while reset is asserted
`define SCF_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset
`define SCF_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/scf_pkg.sv
// Package for the structural contrast filter: sizes, register map, neighbour offsets.
// No dependencies.
package scf_pkg;

  localparam int MaxStrokeDef = 15;
  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeight    = 4096;

  localparam logic [3:0]  StrokeRst = 4'd2;
  localparam logic [10:0] WidthRst  = 11'd640;
  localparam logic [12:0] HeightRst = 13'd480;

  typedef enum logic [1:0] {
    REG_STROKE = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_e;

  // neighbour offsets, index 0 = left, then clockwise
  localparam int NbDx [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
  localparam int NbDy [8] = '{0, -1, -1, -1, 0, 1, 1, 1};

endpackage

// File: hw/rtl/structural_contrast_filter.sv
// Structural contrast filter, top level and only module.
// Depends on scf_pkg and structural_contrast_filter_assert.svh.
`include "structural_contrast_filter_assert.svh"
// Usage:
// Pixels enter on the in channel (pixel_i, flush_i) in raster order; a request
// is taken when in_valid_i is high and in_stall_o low. Flush requests carry no
// pixel and, once the whole frame is in, push out one pending result each.
// Results leave on the out channel (contrast_o, last_o) under out_valid_o and
// out_stall_i; last_o marks the frame's final pixel, after which all position
// counters return to zero for the next frame.
// With a result, the window scan reads the pixel line store one pixel a cycle
// over the (2W+3) square, then an 18-step divider forms the mean. The single
// read port of the line store sets the pace of the scan. The result for pixel p
// comes with the request after (W+1)*width+(W+1) more pixels, or with each
// request once the frame is complete.
// A stalled receiver holds its result in the output register; the next request
// is still taken and worked up to the point where its own result is ready.
// Reset clears counters and state and loads the configuration defaults; the line
// store needs no clearing since every in-frame pixel is written before it is read.
// Configuration: APB writes to stroke_width (0x0), image_width (0x4) and
// image_height (0x8) restart the frame; write only while idle.
module structural_contrast_filter
  import scf_pkg::*;
#(
  parameter int MAX_STROKE = MaxStrokeDef,
  parameter int MAX_WIDTH  = MaxWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_i,
  input  logic        flush_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  contrast_o,
  output logic        last_o
);

  localparam int RING    = 2 * MAX_STROKE + 4;
  localparam int RING_W  = $clog2(RING);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WID_W   = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W   = $clog2(MaxHeight + 1);
  localparam int POS_W   = $clog2(MAX_WIDTH * MaxHeight + 1);
  localparam int SW_W    = $clog2(MAX_STROKE + 2);
  localparam int IDX_W   = $clog2(2 * MAX_STROKE + 3);
  localparam int SUM_W   = $clog2((2 * MAX_STROKE + 1) * (2 * MAX_STROKE + 1) * 255 + 1);
  localparam int AREA_W  = $clog2((2 * MAX_STROKE + 1) * (2 * MAX_STROKE + 1) + 1);
  localparam int SX_W    = COL_W + 3;
  localparam int SY_W    = ROW_W + 2;
  localparam int CNT_W   = $clog2(SUM_W);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_SCAN, ST_DRAIN, ST_REDUCE, ST_DIV, ST_EMIT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [3:0]  stroke_q;
  logic [10:0] width_q;
  logic [12:0] height_q;

  // effective (clamped) configuration and derived constants
  logic [SW_W-1:0]   w_r;
  logic [WID_W-1:0]  w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [POS_W-1:0]  total_q, lag_q;
  logic [AREA_W-1:0] area_q;
  logic [IDX_W-1:0]  span_last;

  // stream position
  logic [COL_W-1:0]  in_col_q, out_col_q;
  logic [ROW_W-1:0]  in_row_q, out_row_q;
  logic [RING_W-1:0] in_ring_q, out_ring_q;
  logic [POS_W-1:0]  rcv_q, out_pos_q;

  // window scan
  logic signed [SX_W-1:0] cx_q, cx0_q;
  logic signed [SY_W-1:0] ry_q;
  logic [RING_W-1:0]      sring_q;
  logic [IDX_W-1:0]       si_q, sj_q;
  logic                   p_v_q, p_in_q;
  logic [IDX_W-1:0]       p_i_q, p_j_q;
  logic [7:0]             rdata_q;
  logic [SUM_W-1:0]       sum_q [8];
  logic [7:0]             g_q;

  // divider
  logic [SUM_W-1:0]  quo_q;
  logic [AREA_W-1:0] rem_q;
  logic [CNT_W-1:0]  cnt_q;

  // output register
  logic       out_valid_q;
  logic [7:0] contrast_q;
  logic       last_q;

  logic [7:0] line_mem [RING][MAX_WIDTH];

  logic cfg_wr, in_acc, store_en, due, scan_in, out_free;
  logic [1:0] cfg_idx;
  logic [SUM_W-1:0] best;
  logic [AREA_W:0]  trial;
  logic signed [SX_W-1:0] cx_start;
  logic signed [SY_W-1:0] ry_start;
  logic [RING_W:0]  sring_start;
  logic [7:0]       mean;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx_e'(cfg_idx))
      REG_STROKE: prdata = {28'd0, stroke_q};
      REG_WIDTH:  prdata = {21'd0, width_q};
      REG_HEIGHT: prdata = {19'd0, height_q};
      default:    prdata = '0;
    endcase
  end

  // clamp registers to their working ranges
  always_comb begin
    if (stroke_q == 4'd0) begin
      w_r = SW_W'(1);
    end else if (32'(stroke_q) > MAX_STROKE) begin
      w_r = SW_W'(MAX_STROKE);
    end else begin
      w_r = SW_W'(stroke_q);
    end
    if (width_q < 11'd8) begin
      w_eff = WID_W'(8);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(width_q);
    end
    if (height_q < 13'd8) begin
      h_eff = ROW_W'(8);
    end else if (32'(height_q) > MaxHeight) begin
      h_eff = ROW_W'(MaxHeight);
    end else begin
      h_eff = ROW_W'(height_q);
    end
  end

  assign span_last = IDX_W'({w_r, 1'b0}) + IDX_W'(2);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign store_en   = !flush_i && (in_row_q < h_eff);
  assign due        = (out_pos_q < total_q) &&
                      ((rcv_q >= total_q) ||
                       ({1'b0, rcv_q} > ({1'b0, out_pos_q} + {1'b0, lag_q})));
  assign scan_in    = (cx_q >= 0) && (ry_q >= 0) &&
                      (cx_q < $signed(SX_W'(w_eff))) && (ry_q < $signed(SY_W'(h_eff)));
  assign out_free   = !out_valid_q || !out_stall_i;

  assign cx_start = $signed(SX_W'(out_col_q)) - $signed(SX_W'(w_r)) - $signed(SX_W'(1));
  assign ry_start = $signed(SY_W'(out_row_q)) - $signed(SY_W'(w_r)) - $signed(SY_W'(1));
  always_comb begin
    if ({1'b0, out_ring_q} >= (RING_W + 1)'(w_r) + (RING_W + 1)'(1)) begin
      sring_start = {1'b0, out_ring_q} - (RING_W + 1)'(w_r) - (RING_W + 1)'(1);
    end else begin
      sring_start = {1'b0, out_ring_q} + (RING_W + 1)'(RING) - (RING_W + 1)'(w_r)
                    - (RING_W + 1)'(1);
    end
  end

  // max over k of the min of four neighbour sums
  always_comb begin
    logic [SUM_W-1:0] m;
    best = '0;
    for (int k = 0; k < 4; k++) begin
      m = sum_q[k];
      if (sum_q[k + 1] < m) m = sum_q[k + 1];
      if (sum_q[k + 4] < m) m = sum_q[k + 4];
      if (sum_q[(k + 5) % 8] < m) m = sum_q[(k + 5) % 8];
      if (m > best) best = m;
    end
  end

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign mean  = quo_q[7:0];

  // line store: write on a stored pixel, read during the window scan
  always_ff @(posedge clk_i) begin
    if (in_acc && store_en) begin
      line_mem[in_ring_q][in_col_q] <= pixel_i;
    end else if (state_q == ST_SCAN) begin
      rdata_q <= line_mem[sring_q][cx_q[COL_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stroke_q    <= StrokeRst;
      width_q     <= WidthRst;
      height_q    <= HeightRst;
      total_q     <= '0;
      lag_q       <= '0;
      area_q      <= '0;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_ring_q   <= '0;
      rcv_q       <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_ring_q  <= '0;
      out_pos_q   <= '0;
      cx_q        <= '0;
      cx0_q       <= '0;
      ry_q        <= '0;
      sring_q     <= '0;
      si_q        <= '0;
      sj_q        <= '0;
      p_v_q       <= 1'b0;
      p_in_q      <= 1'b0;
      p_i_q       <= '0;
      p_j_q       <= '0;
      g_q         <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      contrast_q  <= '0;
      last_q      <= 1'b0;
      for (int k = 0; k < 8; k++) sum_q[k] <= '0;
    end else begin
      // derived constants follow the registers
      total_q <= POS_W'(w_eff * h_eff);
      lag_q   <= POS_W'((w_r + SW_W'(1)) * w_eff) + POS_W'(w_r) + POS_W'(1);
      area_q  <= AREA_W'(({w_r, 1'b1}) * ({w_r, 1'b1}));

      // result taken by the receiver; a new one from ST_EMIT takes its place
      if (out_valid_q && !out_stall_i && state_q != ST_EMIT) out_valid_q <= 1'b0;

      // accumulate the registered line-store read into every matching window
      if (p_v_q) begin
        for (int k = 0; k < 8; k++) begin
          if (p_in_q &&
              int'(p_i_q) >= 1 + NbDy[k] && int'(p_i_q) <= 2 * int'(w_r) + 1 + NbDy[k] &&
              int'(p_j_q) >= 1 + NbDx[k] && int'(p_j_q) <= 2 * int'(w_r) + 1 + NbDx[k]) begin
            sum_q[k] <= sum_q[k] + SUM_W'(rdata_q);
          end
        end
        if (p_in_q && int'(p_i_q) == int'(w_r) + 1 && int'(p_j_q) == int'(w_r) + 1) begin
          g_q <= rdata_q;
        end
      end
      p_v_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (cfg_wr) begin
            case (reg_idx_e'(cfg_idx))
              REG_STROKE: stroke_q <= pwdata[3:0];
              REG_WIDTH:  width_q  <= pwdata[10:0];
              REG_HEIGHT: height_q <= pwdata[12:0];
              default: ;
            endcase
            if (reg_idx_e'(cfg_idx) != REG_NONE) begin
              in_col_q   <= '0;
              in_row_q   <= '0;
              in_ring_q  <= '0;
              rcv_q      <= '0;
              out_col_q  <= '0;
              out_row_q  <= '0;
              out_ring_q <= '0;
              out_pos_q  <= '0;
            end
          end else if (in_acc) begin
            if (store_en) begin
              rcv_q <= rcv_q + POS_W'(1);
              if (WID_W'(in_col_q) + WID_W'(1) == w_eff) begin
                in_col_q <= '0;
                in_row_q <= in_row_q + ROW_W'(1);
                in_ring_q <= (32'(in_ring_q) == RING - 1) ? '0 : in_ring_q + RING_W'(1);
              end else begin
                in_col_q <= in_col_q + COL_W'(1);
              end
            end
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (due) begin
            cx_q    <= cx_start;
            cx0_q   <= cx_start;
            ry_q    <= ry_start;
            sring_q <= sring_start[RING_W-1:0];
            si_q    <= '0;
            sj_q    <= '0;
            for (int k = 0; k < 8; k++) sum_q[k] <= '0;
            state_q <= ST_SCAN;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          p_v_q  <= 1'b1;
          p_in_q <= scan_in;
          p_i_q  <= si_q;
          p_j_q  <= sj_q;
          if (sj_q == span_last) begin
            sj_q    <= '0;
            cx_q    <= cx0_q;
            si_q    <= si_q + IDX_W'(1);
            ry_q    <= ry_q + $signed(SY_W'(1));
            sring_q <= (32'(sring_q) == RING - 1) ? '0 : sring_q + RING_W'(1);
            if (si_q == span_last) state_q <= ST_DRAIN;
          end else begin
            sj_q <= sj_q + IDX_W'(1);
            cx_q <= cx_q + $signed(SX_W'(1));
          end
        end
        ST_DRAIN: begin
          state_q <= ST_REDUCE;
        end
        ST_REDUCE: begin
          quo_q   <= best;
          rem_q   <= '0;
          cnt_q   <= CNT_W'(SUM_W - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          // restoring division, one quotient bit a cycle
          if (trial >= {1'b0, area_q}) begin
            rem_q <= AREA_W'(trial - {1'b0, area_q});
            quo_q <= {quo_q[SUM_W-2:0], 1'b1};
          end else begin
            rem_q <= trial[AREA_W-1:0];
            quo_q <= {quo_q[SUM_W-2:0], 1'b0};
          end
          if (cnt_q == '0) begin
            state_q <= ST_EMIT;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            contrast_q  <= (mean > g_q) ? mean - g_q : 8'd0;
            last_q      <= (out_pos_q + POS_W'(1) == total_q);
            if (out_pos_q + POS_W'(1) == total_q) begin
              in_col_q   <= '0;
              in_row_q   <= '0;
              in_ring_q  <= '0;
              rcv_q      <= '0;
              out_col_q  <= '0;
              out_row_q  <= '0;
              out_ring_q <= '0;
              out_pos_q  <= '0;
            end else begin
              out_pos_q <= out_pos_q + POS_W'(1);
              if (WID_W'(out_col_q) + WID_W'(1) == w_eff) begin
                out_col_q  <= '0;
                out_row_q  <= out_row_q + ROW_W'(1);
                out_ring_q <= (32'(out_ring_q) == RING - 1) ? '0 : out_ring_q + RING_W'(1);
              end else begin
                out_col_q <= out_col_q + COL_W'(1);
              end
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign contrast_o  = contrast_q;
  assign last_o      = last_q;

  `SCF_CHECK(a_acc_idle, in_acc |=> (state_q == ST_DECIDE), "request not followed by decide")
  `SCF_CHECK(a_mean_fits, (state_q == ST_EMIT) |-> (quo_q[SUM_W-1:8] == '0), "mean above 255")
  `SCF_CHECK(a_scan_pos, (state_q == ST_SCAN) |-> (out_pos_q < total_q), "scan past frame end")
  `SCF_CHECK(a_scan_idx, (state_q == ST_SCAN) |-> (si_q <= span_last && sj_q <= span_last),
             "scan index beyond window")
  `SCF_CHECK(a_ring_rng, 32'(in_ring_q) < RING && 32'(out_ring_q) < RING,
             "ring row out of range")
  `SCF_CHECK_ALWAYS(a_rst_idle, !rst_ni |=> (state_q == ST_IDLE && !out_valid_q),
                    "not idle after reset")

endmodule
